// ===== hdl/sha_pkg.sv =====
// Package for the SHA-256 stream hasher: constants, types and a rotate helper.
package sha_pkg;

  localparam logic [31:0] K_TABLE [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H_INIT [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] PAD_WORD = 32'h80000000;

  typedef logic [31:0] word_t;
  typedef word_t hash_t [0:7];

  typedef enum logic [2:0] {
    ST_IDLE, ST_PUSH, ST_ROUND, ST_ADD, ST_OUT
  } state_t;

  // compression core control
  typedef struct packed {
    logic start;
    logic init;
  } core_ctl_t;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== hdl/sha_core.sv =====
// SHA-256 compression unit: one round per cycle with a rolling 16-word schedule.
module sha_core (
  input  logic               clk,
  input  logic               rst,
  input  sha_pkg::core_ctl_t ctl,
  input  sha_pkg::word_t     blk [0:15],
  output logic               busy,
  output logic               done,
  output sha_pkg::word_t     hash [0:7]
);
  import sha_pkg::*;

  word_t w [0:15];
  word_t v [0:7];
  logic [5:0] rnd;
  logic running;
  logic fin;
  word_t t1, t2, s0, s1, w_new;

  always_comb begin
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[rnd] + w[0];
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
  end

  assign busy = running | fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fin     <= 1'b0;
      done    <= 1'b0;
      rnd     <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= H_INIT[i];
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (ctl.init) begin
        for (int i = 0; i < 8; i++) hash[i] <= H_INIT[i];
      end else if (ctl.start) begin
        running <= 1'b1;
        rnd     <= '0;
        for (int i = 0; i < 16; i++) w[i] <= blk[i];
        for (int i = 0; i < 8; i++) v[i] <= hash[i];
      end else if (running) begin
        for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
        w[15] <= w_new;
        for (int i = 1; i < 8; i++) v[i] <= v[i - 1];
        v[4] <= v[3] + t1;
        v[0] <= t1 + t2;
        rnd  <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          running <= 1'b0;
          fin     <= 1'b1;
        end
      end else if (fin) begin
        for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/sha256_stream_hasher.sv =====
// Top level of the SHA-256 stream hasher: word intake, padding sequencer, digest output.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+-----------------------------
//  in      | in_valid, in_ready, data_word,            | message words, big-endian,
//          | valid_bytes, last_word                    | last word with byte count
//  out     | out_valid, out_ready, digest_word,        | eight digest words per
//          | word_index, digest_end                    | message, index 0 first
//
// A word that is neither last nor closes a block leaves in_ready high. A word that
// fills a block holds in_ready low after its transfer while the shared round unit
// is started, runs 64 rounds and folds into the chain value, done is seen and
// ST_ADD passes. A last word pushes its padding one word a cycle and runs one
// or two blocks, then holds each of the eight digest transfers for out_ready.
// Reset (synchronous) reloads the initial hash and empties the buffer.
// in_ready is low while a block or digest is in flight.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  valid_bytes,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        digest_end
);
  import sha_pkg::*;

  state_t state, state_next;
  word_t buffer [0:15];
  logic [3:0] fill;
  logic [60:0] total;
  logic [2:0] out_idx;
  // last word taken: padding and length still owed
  logic last_seen;
  logic second;       // second word of a full last word (the 0x80 marker) owed
  logic [63:0] bits;
  core_ctl_t ctl;
  core_ctl_t core_ctl;
  logic core_busy, core_done;
  word_t hash [0:7];

  logic accept;
  logic [2:0] nb;
  word_t keep, lastw, push_w;
  logic push;
  logic out_fire;

  // set once the high length word is in: this block closes the message
  logic len_phase;

  // ST_ROUND start pulses once: core_busy rises the next cycle
  logic started;

  assign accept = in_valid & in_ready;
  assign nb = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
  assign bits = {total, 3'b000};
  assign out_fire = out_valid & out_ready;

  always_comb begin
    case (nb)
      3'd0: keep = 32'h00000000;
      3'd1: keep = 32'hff000000;
      3'd2: keep = 32'hffff0000;
      3'd3: keep = 32'hffffff00;
      default: keep = 32'hffffffff;
    endcase
    case (nb)
      3'd0: lastw = 32'h80000000;
      3'd1: lastw = (data_word & keep) | 32'h00800000;
      3'd2: lastw = (data_word & keep) | 32'h00008000;
      3'd3: lastw = (data_word & keep) | 32'h00000080;
      default: lastw = data_word;
    endcase
  end

  // word pushed in ST_PUSH: marker, zero fill, then length words
  // slot 15 holds the low length word only after the high one went into slot 14
  always_comb begin
    if (second) push_w = PAD_WORD;
    else if (fill == 4'd14) push_w = bits[63:32];
    else if (fill == 4'd15 && len_phase) push_w = bits[31:0];
    else push_w = '0;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    push       = 1'b0;
    ctl        = '0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (fill == 4'd15) state_next = ST_ROUND;
          else if (last_word) state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        push = 1'b1;
        if (fill == 4'd15) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (!core_busy) ctl.start = 1'b1;
        if (core_done) state_next = ST_ADD;
      end
      ST_ADD: begin
        if (!last_seen) state_next = ST_IDLE;
        else if (len_phase) state_next = ST_OUT;
        else state_next = ST_PUSH;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_fire && out_idx == 3'd7) begin
          ctl.init   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      total     <= '0;
      out_idx   <= '0;
      last_seen <= 1'b0;
      second    <= 1'b0;
      started   <= 1'b0;
      for (int i = 0; i < 16; i++) buffer[i] <= '0;
    end else begin
      state <= state_next;
      if (state == ST_ROUND) started <= 1'b1;
      else started <= 1'b0;
      if (accept) begin
        if (last_word) begin
          last_seen <= 1'b1;
          total <= total + 61'(nb);
          buffer[fill] <= lastw;
          second <= (nb == 3'd4);
        end else begin
          total <= total + 61'd4;
          buffer[fill] <= data_word;
        end
        fill <= fill + 4'd1;
      end
      if (push) begin
        buffer[fill] <= push_w;
        second <= 1'b0;
        fill <= fill + 4'd1;
      end
      if (state == ST_OUT && out_fire) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == 3'd7) begin
          last_seen <= 1'b0;
          fill <= '0;
          total <= '0;
          for (int i = 0; i < 16; i++) buffer[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) len_phase <= 1'b0;
    else if (state == ST_OUT) len_phase <= 1'b0;
    else if (push && !second && fill == 4'd14) len_phase <= 1'b1;
  end

  assign core_ctl.start = ctl.start & ~started;
  assign core_ctl.init  = ctl.init;

  sha_core u_core (
    .clk  (clk),
    .rst  (rst),
    .ctl  (core_ctl),
    .blk  (buffer),
    .busy (core_busy),
    .done (core_done),
    .hash (hash)
  );

  assign digest_word = hash[out_idx];
  assign word_index  = out_idx;
  assign digest_end  = (out_idx == 3'd7);

endmodule
